/* sv/pqft_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// pqft_pkg: shared types and constants for the priority queue
// Queue depth, field widths, action and status codes, sequencer states and
// the sample bundle fed to the running-max unit.
// ============================================================================
package pqft_pkg;

    // Queue geometry
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths
    localparam int ACT_W  = 2;
    localparam int PRIO_W = 16;
    localparam int TAG_W  = 32;
    localparam int STAT_W = 2;
    localparam int ENTRY_W = PRIO_W + TAG_W;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREP,
        S_SHIFT,
        S_DONE
    } state_t;

    // One entry read back from memory, handed to the running-max unit
    typedef struct packed {
        logic              valid;
        logic              first;
        logic [ADDR_W-1:0] idx;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } sample_t;

endpackage

/* sv/pqft_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// pqft_ram: simple dual-port entry memory
// One write port and one read port, read data registered.
// ============================================================================
module pqft_ram #(
    parameter int DATA_W = 48,
    parameter int WORDS  = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(WORDS)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [WORDS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* sv/pqft_max.sv */
`timescale 1ns / 1ps
// ============================================================================
// pqft_max: running maximum over a stream of entries
// Keeps the first slot holding the largest priority seen since the first
// sample; a later equal priority does not replace it.
// ============================================================================
module pqft_max (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pqft_pkg::sample_t         sample,
    output logic [pqft_pkg::ADDR_W-1:0] best_idx,
    output logic [pqft_pkg::TAG_W-1:0]  best_tag
);
    import pqft_pkg::*;

    logic [PRIO_W-1:0] best_prio_reg;
    logic [ADDR_W-1:0] best_idx_reg;
    logic [TAG_W-1:0]  best_tag_reg;
    logic              take;

    // Strict compare keeps the earliest slot among equal priorities
    assign take = sample.valid && (sample.first || (sample.prio > best_prio_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_idx_reg <= '0;
        end
        else if (take)
        begin
            best_idx_reg <= sample.idx;
        end
    end

    // Payload of the best entry
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_prio_reg <= sample.prio;
            best_tag_reg  <= sample.tag;
        end
    end

    assign best_idx = best_idx_reg;
    assign best_tag = best_tag_reg;

endmodule

/* sv/priority_queue_fifo_tiebreak.sv */
`timescale 1ns / 1ps
// ============================================================================
// priority_queue_fifo_tiebreak: bounded max-priority queue, FIFO tie break
// Entries sit packed in arrival order in a one-read, one-write memory; a pop
// scans them for the first maximum and closes the gap by moving later
// entries down one slot.
// ============================================================================
// Insert, clear and the unused action are accepted in idle and post their
// result from the done state. A pop of a non-empty queue is accepted, then
// scans every occupied slot, sets up the move-down, moves each later entry
// down one slot past the best one and posts the result; every scan and move
// step goes through the single memory read port. One request is in work at
// a time; a new request is taken while the previous result still waits at
// the output. The entry memory needs no clearing after reset: only slots
// below the fill count are ever read. Pop on an empty queue reports status
// 1 and insert on a full queue reports status 2, with the entry dropped.
module priority_queue_fifo_tiebreak (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [pqft_pkg::ACT_W-1:0]  action,
    input  logic [pqft_pkg::PRIO_W-1:0] priority_req,
    input  logic [pqft_pkg::TAG_W-1:0]  tag,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [pqft_pkg::TAG_W-1:0]  out_tag,
    output logic                        out_valid,
    output logic [pqft_pkg::STAT_W-1:0] status
);
    import pqft_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              dv_reg, dv_next;
    logic [ADDR_W-1:0] da_reg, da_next;

    logic [TAG_W-1:0]  pend_tag_reg, pend_tag_next;
    logic              pend_ov_reg, pend_ov_next;
    logic [STAT_W-1:0] pend_st_reg, pend_st_next;

    logic              res_valid_reg, res_valid_next;
    logic [TAG_W-1:0]  out_tag_reg, out_tag_next;
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    sample_t            sample;
    logic [ADDR_W-1:0]  best_idx;
    logic [TAG_W-1:0]   best_tag;

    logic req_fire;
    logic issue;
    logic scan_last;
    logic shift_end;
    logic out_free;

    // Entry memory
    pqft_ram #(
        .DATA_W (ENTRY_W),
        .WORDS  (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Running-max compare unit
    pqft_max u_max (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample),
        .best_idx (best_idx),
        .best_tag (best_tag)
    );

    // Handshake and sequencing terms
    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign issue     = (iss_reg < occ_reg);
    assign scan_last = dv_reg && (CNT_W'(da_reg) == (occ_reg - 1'b1));
    assign shift_end = !issue && !dv_reg;
    assign out_free  = !res_valid_reg || res_ready;
    assign mem_raddr = iss_reg[ADDR_W-1:0];

    // Sample feed to the compare unit during the scan
    always_comb
    begin
        sample.valid = (state_reg == S_SCAN) && dv_reg;
        sample.first = (da_reg == '0);
        sample.idx   = da_reg;
        sample.prio  = mem_rdata[ENTRY_W-1:TAG_W];
        sample.tag   = mem_rdata[TAG_W-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if ((action == ACT_POP) && (occ_reg != '0))
                        state_next = S_SCAN;
                    else
                        state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (shift_end)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        occ_next       = occ_reg;
        iss_next       = iss_reg;
        dv_next        = 1'b0;
        da_next        = da_reg;
        pend_tag_next  = pend_tag_reg;
        pend_ov_next   = pend_ov_reg;
        pend_st_next   = pend_st_reg;
        res_valid_next = res_valid_reg;
        out_tag_next   = out_tag_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = occ_reg[ADDR_W-1:0];
        mem_wdata      = {priority_req, tag};

        // Result taken downstream
        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                iss_next = '0;
                if (req_fire)
                begin
                    pend_tag_next = '0;
                    pend_ov_next  = 1'b0;
                    pend_st_next  = ST_OK;
                    unique case (action)
                        ACT_INSERT:
                        begin
                            if (occ_reg >= CNT_W'(DEPTH))
                            begin
                                pend_st_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        ACT_POP:
                        begin
                            if (occ_reg == '0)
                                pend_st_next = ST_EMPTY;
                        end
                        ACT_CLEAR:
                        begin
                            occ_next = '0;
                        end
                        default:
                        begin
                            pend_st_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Stream slots 0..occ-1 through the compare unit
                if (issue)
                begin
                    iss_next = iss_reg + 1'b1;
                    dv_next  = 1'b1;
                    da_next  = iss_reg[ADDR_W-1:0];
                end
            end
            S_PREP:
            begin
                iss_next = CNT_W'(best_idx) + 1'b1;
            end
            S_SHIFT:
            begin
                // Read slot i+1, write it back to slot i
                if (issue)
                begin
                    iss_next = iss_reg + 1'b1;
                    dv_next  = 1'b1;
                    da_next  = iss_reg[ADDR_W-1:0];
                end
                if (dv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = da_reg - 1'b1;
                    mem_wdata = mem_rdata;
                end
                if (shift_end)
                begin
                    occ_next      = occ_reg - 1'b1;
                    pend_tag_next = best_tag;
                    pend_ov_next  = 1'b1;
                    pend_st_next  = ST_OK;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    out_tag_next   = pend_tag_reg;
                    out_valid_next = pend_ov_reg;
                    status_next    = pend_st_reg;
                end
            end
            default:
            begin
                iss_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            iss_reg       <= '0;
            dv_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            iss_reg       <= iss_next;
            dv_reg        <= dv_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        da_reg        <= da_next;
        pend_tag_reg  <= pend_tag_next;
        pend_ov_reg   <= pend_ov_next;
        pend_st_reg   <= pend_st_next;
        out_tag_reg   <= out_tag_next;
        out_valid_reg <= out_valid_next;
        status_reg    <= status_next;
    end

    assign res_valid = res_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // Fill count never exceeds the queue depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // Move-down writes stay inside the occupied slots
    a_shift_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) && mem_we |-> (CNT_W'(mem_waddr) < occ_reg))
        else $error("move-down write outside queue");

    // Pop on an empty queue is flagged on the next cycle
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (action == ACT_POP) && (occ_reg == '0)
        |=> (state_reg == S_DONE) && (pend_st_reg == ST_EMPTY) && !pend_ov_reg)
        else $error("empty pop not flagged");

    // Accepted insert with room grows the fill count by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (action == ACT_INSERT) && (occ_reg < CNT_W'(DEPTH))
        |=> (occ_reg == $past(occ_reg) + 1'b1))
        else $error("insert did not grow queue");

    // A popped tag always comes with ok status
    a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> (status == ST_OK))
        else $error("popped tag with error status");
`endif

endmodule
